// ----- rtl/core/hfc_pkg.sv -----
// Package with shared types, constants and the CRC byte update for the HDLC frame checker.
`timescale 1ns / 1ps
package hfc_pkg;

  localparam int unsigned MaxUnescapedDefault = 256;
  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  // Raw byte count saturates at 4; a frame needs at least that many.
  localparam int unsigned RawCntW   = 3;
  localparam int unsigned MinRawLen = 4;

  typedef enum logic {
    CMD_DATA,
    CMD_END
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_CRC      = 2'd3
  } status_e;

  // One request from the front to the back.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;     // unescaped byte for CMD_DATA
    logic       fmt_err;  // short frame or bad flag, CMD_END only
    logic       esc_open; // frame ended right after an escape, CMD_END only
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/core/hfc_front.sv -----
// Front end: takes raw bytes, checks flags, strips escapes and issues requests.
`timescale 1ns / 1ps
module hfc_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   in_data_i,
  input  logic         in_last_i,
  input  logic         q_full_i,
  output logic         cmd_valid_o,
  output hfc_pkg::cmd_t cmd_o
);
  import hfc_pkg::*;

  logic [RawCntW-1:0] raw_cnt_q, raw_cnt_d;
  logic               open_ok_q, open_ok_d;
  logic               esc_q, esc_d;
  logic               accept;
  logic               first;
  logic               open_now;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign first      = (raw_cnt_q == '0);
  assign open_now   = first ? (in_data_i == FlagByte) : open_ok_q;

  always_comb begin
    raw_cnt_d   = raw_cnt_q;
    open_ok_d   = open_ok_q;
    esc_d       = esc_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind     = CMD_DATA;
    cmd_o.data     = in_data_i;
    cmd_o.fmt_err  = 1'b0;
    cmd_o.esc_open = esc_q;
    if (accept) begin
      if (in_last_i) begin
        cmd_valid_o   = 1'b1;
        cmd_o.kind    = CMD_END;
        cmd_o.fmt_err = (raw_cnt_q < RawCntW'(MinRawLen - 1)) || !open_now ||
                        (in_data_i != FlagByte);
        raw_cnt_d     = '0;
        open_ok_d     = 1'b0;
        esc_d         = 1'b0;
      end else begin
        if (raw_cnt_q < RawCntW'(MinRawLen)) begin
          raw_cnt_d = raw_cnt_q + RawCntW'(1);
        end
        if (first) begin
          open_ok_d = open_now;
        end else if (esc_q) begin
          esc_d       = 1'b0;
          cmd_valid_o = 1'b1;
          cmd_o.data  = in_data_i ^ EscXor;
        end else if (in_data_i == EscByte) begin
          esc_d = 1'b1;
        end else begin
          cmd_valid_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cnt_q <= '0;
      open_ok_q <= 1'b0;
      esc_q     <= 1'b0;
    end else begin
      raw_cnt_q <= raw_cnt_d;
      open_ok_q <= open_ok_d;
      esc_q     <= esc_d;
    end
  end

endmodule

// ----- rtl/core/hfc_queue.sv -----
// Two-entry request queue between the front end and the back end.
`timescale 1ns / 1ps
module hfc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hfc_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output hfc_pkg::cmd_t pop_cmd_o
);
  import hfc_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_cmd_o   = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/hfc_back.sv -----
// Back end: holds back two bytes, runs the CRC and builds the frame status.
`timescale 1ns / 1ps
module hfc_back #(
  parameter int unsigned MaxUnescaped = hfc_pkg::MaxUnescapedDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  hfc_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    out_status_o,
  output logic [7:0]    out_length_o,
  output logic [15:0]   out_crc_o
);
  import hfc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxUnescaped + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      held_q [2];
  logic [7:0]      held_d [2];
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [7:0]      length_q, length_d;
  logic [15:0]     rcv_q, rcv_d;
  logic            pop;
  logic [15:0]     rcv;
  logic [CntW-1:0] plen_full;

  // An end request waits for the output register; data requests never wait.
  assign pop       = cmd_valid_i && ((cmd_i.kind == CMD_DATA) || !out_valid_q || out_ready_i);
  assign cmd_pop_o = pop;
  assign rcv       = {held_q[1], held_q[0]};
  assign plen_full = cnt_q - CntW'(2);

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    crc_d       = crc_q;
    held_d      = held_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    length_d    = length_q;
    rcv_d       = rcv_q;
    if (pop) begin
      if (cmd_i.kind == CMD_DATA) begin
        if (!ovf_q) begin
          if (cnt_q >= CntW'(MaxUnescaped)) begin
            ovf_d = 1'b1;
          end else begin
            if (cnt_q >= CntW'(2)) begin
              crc_d = crc_byte(crc_q, held_q[0]);
            end
            held_d[0] = held_q[1];
            held_d[1] = cmd_i.data;
            cnt_d     = cnt_q + CntW'(1);
          end
        end
      end else begin
        out_valid_d = 1'b1;
        length_d    = '0;
        rcv_d       = '0;
        if (cmd_i.fmt_err) begin
          status_d = ST_FORMAT;
        end else if (ovf_q) begin
          status_d = ST_TOO_LONG;
        end else if (cmd_i.esc_open || (cnt_q < CntW'(3))) begin
          status_d = ST_FORMAT;
        end else begin
          rcv_d = rcv;
          if (crc_q != rcv) begin
            status_d = ST_CRC;
          end else begin
            status_d = ST_OK;
            length_d = (plen_full > CntW'(255)) ? 8'hFF : 8'(plen_full);
          end
        end
        // Clear frame state for the next frame.
        cnt_d     = '0;
        ovf_d     = 1'b0;
        crc_d     = CrcInit;
        held_d[0] = '0;
        held_d[1] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q   <= held_d;
    status_q <= status_d;
    length_q <= length_d;
    rcv_q    <= rcv_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_length_o = length_q;
  assign out_crc_o    = rcv_q;

endmodule

// ----- rtl/core/hdlc_frame_checker_unit.sv -----
// Top level of the HDLC frame checker: front end, request queue and back end.
// Path: with the output register free, a closing byte is first written into the request
// queue and its status is then registered in the output register.
// Throughput: one byte per cycle while the queue is not full; the back end takes one
// queued request per cycle, and only an end-of-frame request waits on the output register.
// Reset: asynchronous, active low; clears frame state, queue and output valid.
`timescale 1ns / 1ps
module hdlc_frame_checker_unit #(
  parameter int unsigned MaxUnescaped = hfc_pkg::MaxUnescapedDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [1:0] status, [9:2] payload_length,
                                      // [25:10] frame_fcs, [31:26] zero
);
  import hfc_pkg::*;

  logic        cmd_valid;
  cmd_t        cmd;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_cmd;
  logic [1:0]  status;
  logic [7:0]  length;
  logic [15:0] crc_rcv;

  hfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  hfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_cmd_i  (cmd),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_cmd_o   (q_cmd)
  );

  hfc_back #(
    .MaxUnescaped (MaxUnescaped)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_length_o (length),
    .out_crc_o    (crc_rcv)
  );

  assign m_axis_tdata = {6'b0, crc_rcv, length, status};

endmodule

// ----- tb/sv/hdlc_status_checker.sv -----
// Watches both streams of the HDLC frame checker, predicts each frame status and compares.
`timescale 1ns / 1ps
module hdlc_status_checker #(
  parameter int unsigned MaxUnescaped = hfc_pkg::MaxUnescapedDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import hfc_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [7:0]  payload_len;
    logic [15:0] fcs_rx;
  } frame_status_t;

  frame_status_t status_q [$];

  // Frame state of the predictor.
  logic [RawCntW-1:0] raw_seen;
  logic               lead_flag_ok;
  logic               esc_armed;
  logic               overrun;
  int unsigned        body_cnt;
  logic [15:0]        crc_run;
  logic [7:0]         tail_byte [2];

  // Bit-serial form of the CCITT update, MSB of the byte first.
  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  task automatic clear_frame();
    raw_seen     = '0;
    lead_flag_ok = 1'b0;
    esc_armed    = 1'b0;
    overrun      = 1'b0;
    body_cnt     = 0;
    crc_run      = CrcInit;
    tail_byte[0] = '0;
    tail_byte[1] = '0;
  endtask

  // Shift an unescaped byte into the two-byte hold-back; the oldest one enters the CRC.
  task automatic push_body(input logic [7:0] b);
    if (body_cnt >= MaxUnescaped) begin
      overrun = 1'b1;
    end else begin
      if (body_cnt >= 2) begin
        crc_run = fcs_update(crc_run, tail_byte[0]);
      end
      tail_byte[0] = tail_byte[1];
      tail_byte[1] = b;
      body_cnt++;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    frame_status_t want;
    logic          first;
    logic [15:0]   fcs_seen;
    first = (raw_seen == '0);
    if (raw_seen < MinRawLen) begin
      raw_seen = raw_seen + 1'b1;
    end
    if (first) begin
      lead_flag_ok = (b == FlagByte);
    end
    if (!last) begin
      if (!first && !overrun) begin
        if (esc_armed) begin
          esc_armed = 1'b0;
          push_body(b ^ EscXor);
        end else if (b == EscByte) begin
          esc_armed = 1'b1;
        end else begin
          push_body(b);
        end
      end
    end else begin
      want.status      = ST_OK;
      want.payload_len = '0;
      want.fcs_rx      = '0;
      fcs_seen         = {tail_byte[1], tail_byte[0]};
      if (raw_seen < MinRawLen || !lead_flag_ok || b != FlagByte) begin
        want.status = ST_FORMAT;
      end else if (overrun) begin
        want.status = ST_TOO_LONG;
      end else if (esc_armed || body_cnt < 3) begin
        want.status = ST_FORMAT;
      end else begin
        want.fcs_rx = fcs_seen;
        if (crc_run != fcs_seen) begin
          want.status = ST_CRC;
        end else begin
          want.payload_len = (body_cnt - 2 > 255) ? 8'd255 : 8'(body_cnt - 2);
        end
      end
      status_q.push_back(want);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t: frame status %s got 0x%0h, predicted 0x%0h", $time, field, seen,
             wanted);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    frame_status_t want;
    if (!rst_ni) begin
      clear_frame();
      status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("with no frame outstanding", m_tdata_i, '0);
        end else begin
          want = status_q.pop_front();
          if (m_tdata_i[1:0] != want.status) begin
            report_mismatch("status", 32'(m_tdata_i[1:0]), 32'(want.status));
          end
          if (m_tdata_i[9:2] != want.payload_len) begin
            report_mismatch("payload_length", 32'(m_tdata_i[9:2]), 32'(want.payload_len));
          end
          if (m_tdata_i[25:10] != want.fcs_rx) begin
            report_mismatch("frame_fcs", 32'(m_tdata_i[25:10]), 32'(want.fcs_rx));
          end
          if (m_tdata_i[31:26] != '0) begin
            report_mismatch("padding", 32'(m_tdata_i[31:26]), '0);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_byte(s_tdata_i, s_tlast_i);
      end
      pending_o = status_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the HDLC frame checker testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import hfc_pkg::*;

  localparam int unsigned MaxUnescaped = MaxUnescapedDefault;
  localparam int unsigned ByteBudget   = 1850;

  typedef enum {
    ESC_NEEDED,
    ESC_EVERY,
    ESC_ESC_ONLY
  } esc_style_e;

  typedef enum {
    FAULT_NONE,
    FAULT_BITFLIP,
    FAULT_OPEN_FLAG,
    FAULT_CLOSE_FLAG,
    FAULT_TRUNCATE,
    FAULT_ESC_AT_END,
    FAULT_DROP_BYTE,
    FAULT_NOISE,
    FAULT_LONG,
    FAULT_BAD_FCS
  } frame_fault_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;

  logic [7:0]  body_bytes [$];
  logic [7:0]  raw_frame [$];
  int unsigned burst_left = 0;
  int unsigned sent_bytes = 0;

  logic [1:0]  stall_mode = '0;
  int unsigned mode_left  = 0;
  int unsigned stall_tick = 0;

  hdlc_frame_checker_unit #(
    .MaxUnescaped(MaxUnescaped)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  hdlc_status_checker #(
    .MaxUnescaped(MaxUnescaped)
  ) i_status_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: switch between always ready, random, mostly stalled and slow toggling.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left  <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= stall_tick[2];
    endcase
  end

  function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    repeat (8) begin
      acc = acc[15] ? ({acc[14:0], 1'b0} ^ CrcPoly) : {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  // Present one byte and hold it until the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic send_frame();
    foreach (raw_frame[i]) begin
      send_byte(raw_frame[i], i == raw_frame.size() - 1);
    end
  endtask

  // Random payload, biased toward the flag, the escape and their escaped forms.
  task automatic fill_payload(input int unsigned n);
    body_bytes.delete();
    repeat (n) begin
      case ($urandom_range(0, 11))
        0: body_bytes.push_back(FlagByte);
        1: body_bytes.push_back(EscByte);
        2: body_bytes.push_back(FlagByte ^ EscXor);
        3: body_bytes.push_back(EscByte ^ EscXor);
        default: body_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Append the FCS (low byte first), stuff the bytes and add both flags.
  task automatic wrap_frame(input esc_style_e style, input logic [15:0] fcs_xor);
    logic [15:0] fcs;
    logic [7:0]  unit [$];
    fcs = CrcInit;
    foreach (body_bytes[i]) begin
      fcs = fcs_next(fcs, body_bytes[i]);
    end
    fcs = fcs ^ fcs_xor;
    unit = body_bytes;
    unit.push_back(fcs[7:0]);
    unit.push_back(fcs[15:8]);
    raw_frame.delete();
    raw_frame.push_back(FlagByte);
    foreach (unit[i]) begin
      if (style == ESC_EVERY || unit[i] == EscByte ||
          (unit[i] == FlagByte && style == ESC_NEEDED)) begin
        raw_frame.push_back(EscByte);
        raw_frame.push_back(unit[i] ^ EscXor);
      end else begin
        raw_frame.push_back(unit[i]);
      end
    end
    raw_frame.push_back(FlagByte);
  endtask

  task automatic directed_frames();
    body_bytes = {8'h00};
    wrap_frame(ESC_NEEDED, '0);
    send_frame();
    body_bytes = {8'hFF, 8'hFF, 8'hFF};
    wrap_frame(ESC_NEEDED, '0);
    send_frame();
    body_bytes = {FlagByte, EscByte, 8'h11};
    wrap_frame(ESC_NEEDED, '0);
    send_frame();
    // escaped escape and escaped flag decode to plain data
    body_bytes = {8'h5D, 8'h5E, EscByte};
    wrap_frame(ESC_EVERY, '0);
    send_frame();
    // bare flag between the flags is plain data
    body_bytes = {FlagByte, 8'h42, FlagByte};
    wrap_frame(ESC_ESC_ONLY, '0);
    send_frame();
    body_bytes.delete();
    wrap_frame(ESC_NEEDED, '0);
    send_frame();
    raw_frame = {FlagByte};
    send_frame();
    raw_frame = {8'h00};
    send_frame();
    raw_frame = {FlagByte, 8'h55, FlagByte};
    send_frame();
    raw_frame = {FlagByte, 8'h01, 8'h02, FlagByte};
    send_frame();
    fill_payload(4);
    wrap_frame(ESC_NEEDED, '0);
    raw_frame[0] = 8'h7F;
    send_frame();
    fill_payload(4);
    wrap_frame(ESC_NEEDED, '0);
    raw_frame[raw_frame.size() - 1] = 8'h00;
    send_frame();
    fill_payload(5);
    wrap_frame(ESC_NEEDED, '0);
    raw_frame.insert(raw_frame.size() - 1, EscByte);
    send_frame();
    fill_payload(6);
    wrap_frame(ESC_NEEDED, 16'h8001);
    send_frame();
    fill_payload(MaxUnescaped - 2);
    wrap_frame(ESC_NEEDED, '0);
    send_frame();
    fill_payload(MaxUnescaped - 1);
    wrap_frame(ESC_NEEDED, '0);
    send_frame();
    // bad closing flag outranks the overflow
    fill_payload(MaxUnescaped);
    wrap_frame(ESC_NEEDED, '0);
    raw_frame[raw_frame.size() - 1] = 8'h00;
    send_frame();
  endtask

  function automatic frame_fault_e pick_fault();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return FAULT_NONE;
    if (r < 65) return FAULT_BITFLIP;
    if (r < 70) return FAULT_OPEN_FLAG;
    if (r < 75) return FAULT_CLOSE_FLAG;
    if (r < 80) return FAULT_TRUNCATE;
    if (r < 84) return FAULT_ESC_AT_END;
    if (r < 88) return FAULT_DROP_BYTE;
    if (r < 94) return FAULT_NOISE;
    if (r < 99) return FAULT_BAD_FCS;
    return FAULT_LONG;
  endfunction

  task automatic random_frame();
    frame_fault_e fault;
    int unsigned  idx;
    int unsigned  cut;
    fault = pick_fault();
    fill_payload(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24));
    wrap_frame(esc_style_e'($urandom_range(0, 2)),
               (fault == FAULT_BAD_FCS) ? 16'($urandom_range(1, 65535)) : 16'h0000);
    idx = $urandom_range(1, raw_frame.size() - 2);
    case (fault)
      FAULT_BITFLIP:    raw_frame[idx] = raw_frame[idx] ^ 8'(1 << $urandom_range(0, 7));
      FAULT_OPEN_FLAG:  raw_frame[0] = FlagByte ^ 8'($urandom_range(1, 255));
      FAULT_CLOSE_FLAG: raw_frame[raw_frame.size() - 1] = FlagByte ^ 8'($urandom_range(1, 255));
      FAULT_TRUNCATE: begin
        cut = $urandom_range(1, 3);
        while (raw_frame.size() > cut) void'(raw_frame.pop_back());
      end
      FAULT_ESC_AT_END: raw_frame.insert(raw_frame.size() - 1, EscByte);
      FAULT_DROP_BYTE:  raw_frame.delete(idx);
      FAULT_NOISE: begin
        raw_frame.delete();
        repeat ($urandom_range(1, 12)) raw_frame.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) begin
          raw_frame[0] = FlagByte;
        end
      end
      FAULT_LONG: begin
        fill_payload($urandom_range(MaxUnescaped - 4, MaxUnescaped + 1));
        wrap_frame(ESC_NEEDED, '0);
      end
      default: ;
    endcase
    send_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_frames();
    // fill the rest of the byte budget with random frames
    while (sent_bytes < ByteBudget) begin
      random_frame();
    end
    s_axis_tvalid <= 1'b0;
    // read the outstanding count away from the edge where it changes
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
